[rtl/core/reliable_link_tracker_unit_defines.svh]
// assertion macros for the link tracker checker
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef RELIABLE_LINK_TRACKER_UNIT_DEFINES_SVH
`define RELIABLE_LINK_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define RLT_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rlt_pkg.sv]
// shared types, constants and helpers of the link tracker
// no dependencies
package rlt_pkg;

  localparam int unsigned DEPTH    = 32;
  localparam int unsigned IDXW     = $clog2(DEPTH);
  localparam int unsigned CNTW     = IDXW + 1;
  localparam int unsigned AVG_FRAC = 8;
  localparam int unsigned AVG_W    = 40;
  localparam int unsigned PROD_W   = AVG_W + 9;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned NUM_W    = 32 + PCT_W;
  localparam int unsigned DEN_W    = 33;
  localparam int unsigned STEPW    = $clog2(PCT_W);

  localparam logic [2:0] ACT_RECV = 3'd0;
  localparam logic [2:0] ACT_NEXT = 3'd1;
  localparam logic [2:0] ACT_ADD  = 3'd2;
  localparam logic [2:0] ACT_ACK  = 3'd3;
  localparam logic [2:0] ACT_SCAN = 3'd4;

  localparam logic [2:0] KIND_STATUS = 3'd0;
  localparam logic [2:0] KIND_OUTID  = 3'd1;
  localparam logic [2:0] KIND_RETRY  = 3'd2;
  localparam logic [2:0] KIND_GIVEUP = 3'd3;
  localparam logic [2:0] KIND_FULL   = 3'd4;

  localparam logic [1:0] CFG_RETRY_TO = 2'd0;
  localparam logic [1:0] CFG_ALIVE_TO = 2'd1;
  localparam logic [1:0] CFG_MAX_RETR = 2'd2;
  localparam logic [1:0] CFG_SCAN_EN  = 2'd3;

  typedef struct packed {
    logic [1:0]  retries;
    logic [31:0] sent;
    logic [31:0] seq;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [1:0]  prior_retries;
    logic [31:0] seq;
    logic [31:0] now_ms;
    logic [2:0]  action;
  } in_data_t;

  typedef struct packed {
    logic [31:0]      oldest_unacked;
    logic [5:0]       unacked_count;
    logic [AVG_W-1:0] ping_avg_q8;
    logic [31:0]      ping_last_ms;
    logic [PCT_W-1:0] loss_percent;
    logic [31:0]      packets_lost;
    logic [31:0]      packets_in;
    logic             alive;
    logic [1:0]       retry_count;
    logic [31:0]      seq_out;
  } out_data_t;

  function automatic logic [1:0] sat_inc(logic [1:0] r);
    return (r == 2'd3) ? r : r + 2'd1;
  endfunction

endpackage

[rtl/core/rlt_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module rlt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/rlt_div.sv]
// restoring divider for the loss percentage, one quotient bit a cycle
// depends on rlt_pkg
module rlt_div import rlt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [PCT_W-1:0] quot_o
);

  logic [NUM_W-1:0] rem_q, rem_d, dsh_q, dsh_d;
  logic [PCT_W-1:0] quot_q, quot_d;
  logic [STEPW-1:0] step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic             ge;

  assign ge = rem_q >= dsh_q;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      dsh_d  = NUM_W'({den_i, {(PCT_W-1){1'b0}}});
      quot_d = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? rem_q - dsh_q : rem_q;
      quot_d = {quot_q[PCT_W-2:0], ge};
      dsh_d  = dsh_q >> 1;
      step_d = step_q + 1'b1;
      if (step_q == STEPW'(PCT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[rtl/core/reliable_link_tracker_unit.sv]
// Reliability tracker for one link: receive accounting, outgoing ids, a 32-entry
// unacknowledged table in ram, round-trip averaging and timeout scans. One word
// is taken at a time; the block is not ready until all its result words are out.
// A receive runs the loss-percentage divider, which gives one bit a cycle; an add
// and an acknowledge make one sweep of the table ram, one entry a cycle, and a
// matching acknowledge then does the round-trip averaging. A scan makes one sweep,
// then one more for each expired entry, so that each retry or give-up comes out in
// ascending sequence order. Each result also waits for m_axis_tready_i.
// Depends on rlt_pkg, rlt_ram and rlt_div.
module reliable_link_tracker_unit import rlt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // action, now_ms, seq, prior_retries, zero pad
  input  logic [71:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // seq_out, retry_count, alive, packets_in, packets_lost, loss_percent,
  // ping_last_ms, ping_avg_q8, unacked_count, oldest_unacked
  output logic [215:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  // kind
  output logic [2:0]   m_axis_tuser_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DSTART = 4'd1;
  localparam logic [3:0] ST_DWAIT  = 4'd2;
  localparam logic [3:0] ST_WALK   = 4'd3;
  localparam logic [3:0] ST_POST   = 4'd4;
  localparam logic [3:0] ST_AVG1   = 4'd5;
  localparam logic [3:0] ST_AVG2   = 4'd6;
  localparam logic [3:0] ST_EMIT   = 4'd7;
  localparam logic [3:0] ST_OWAIT  = 4'd8;
  localparam logic [3:0] ST_SNEXT  = 4'd9;

  localparam logic [1:0] W_ADD  = 2'd0;
  localparam logic [1:0] W_ACK  = 2'd1;
  localparam logic [1:0] W_SCAN = 2'd2;
  localparam logic [1:0] W_SEL  = 2'd3;

  in_data_t in_w;
  assign in_w = in_data_t'(s_axis_tdata_i[$bits(in_data_t)-1:0]);

  // configuration
  logic [31:0] rto_q, ato_q;
  logic [1:0]  maxr_q;
  logic        scen_q;

  // link state
  logic [31:0]       exp_q, exp_d, nxt_q, nxt_d, rcv_q, rcv_d, lost_q, lost_d;
  logic [PCT_W-1:0]  pct_q, pct_d;
  logic [31:0]       rtt_q, rtt_d, old_q, old_d, lrx_q, lrx_d;
  logic [AVG_W-1:0]  avg_q, avg_d;
  logic              alive_q, alive_d;
  logic [DEPTH-1:0]  valid_q, valid_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;

  // sequencer
  logic [3:0]        state_q, state_d;
  logic [1:0]        wmode_q, wmode_d;
  logic [31:0]       now_q, now_d, seq_q, seq_d;
  logic [1:0]        prior_q, prior_d;
  logic [CNTW-1:0]   wcnt_q, wcnt_d;
  logic              match_q, match_d, free_q, free_d, minf_q, minf_d;
  logic [IDXW-1:0]   midx_q, midx_d, fidx_q, fidx_d;
  logic [31:0]       mtime_q, mtime_d, min_q, min_d;
  logic [DEPTH-1:0]  mask_q, mask_d;
  logic [CNTW-1:0]   mcnt_q, mcnt_d, gcnt_q, gcnt_d;
  logic              self_q, self_d;
  logic [IDXW-1:0]   sidx_q, sidx_d;
  logic [31:0]       sseq_q, sseq_d;
  logic [1:0]        sret_q, sret_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  // pending result word
  logic [2:0]  ekind_q, ekind_d;
  logic [31:0] eseq_q, eseq_d;
  logic [1:0]  erc_q, erc_d;
  logic        elast_q, elast_d;

  // output register
  logic        ovalid_q, ovalid_d, olast_q, olast_d;
  logic [2:0]  okind_q, okind_d;
  out_data_t   odata_q, odata_d;

  // table ram
  logic            ram_we;
  logic [IDXW-1:0] ram_waddr;
  entry_t          ram_wdata, rd;
  logic [ENTRY_W-1:0] ram_rdata;

  // divider
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [PCT_W-1:0] div_quot;

  logic [IDXW-1:0]  pidx;
  logic [31:0]      elapsed, rcv_inc;
  logic [1:0]       rinc;
  logic [AVG_W-1:0] pq;
  logic [PROD_W-1:0] pq_ext, avg_ext, sum_w;
  logic [CNTW-1:0]  newcnt;

  rlt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(wcnt_q[IDXW-1:0]),
    .rdata_o(ram_rdata)
  );

  rlt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign rd      = entry_t'(ram_rdata);
  assign pidx    = IDXW'(wcnt_q - 1'b1);
  assign elapsed = now_q - rd.sent;
  assign rinc    = sat_inc(rd.retries);
  assign rcv_inc = rcv_q + 32'd1;
  assign pq      = AVG_W'({rtt_q, {AVG_FRAC{1'b0}}});
  assign pq_ext  = PROD_W'(pq);
  assign avg_ext = PROD_W'(avg_q);
  assign sum_w   = prod_q + (pq_ext << 3) + (pq_ext << 2) + pq_ext;
  assign newcnt  = match_q ? cnt_q : cnt_q + 1'b1;

  assign div_num = (NUM_W'(lost_q) << 6) + (NUM_W'(lost_q) << 5) + (NUM_W'(lost_q) << 2);
  assign div_den = DEN_W'(rcv_q) + DEN_W'(lost_q);

  always_comb begin
    exp_d = exp_q;  nxt_d = nxt_q;  rcv_d = rcv_q;  lost_d = lost_q;
    pct_d = pct_q;  rtt_d = rtt_q;  old_d = old_q;  lrx_d = lrx_q;
    avg_d = avg_q;  alive_d = alive_q;  valid_d = valid_q;  cnt_d = cnt_q;
    state_d = state_q;  wmode_d = wmode_q;
    now_d = now_q;  seq_d = seq_q;  prior_d = prior_q;  wcnt_d = wcnt_q;
    match_d = match_q;  free_d = free_q;  minf_d = minf_q;
    midx_d = midx_q;  fidx_d = fidx_q;  mtime_d = mtime_q;  min_d = min_q;
    mask_d = mask_q;  mcnt_d = mcnt_q;  gcnt_d = gcnt_q;
    self_d = self_q;  sidx_d = sidx_q;  sseq_d = sseq_q;  sret_d = sret_q;
    prod_d = prod_q;
    ekind_d = ekind_q;  eseq_d = eseq_q;  erc_d = erc_q;  elast_d = elast_q;
    ovalid_d = ovalid_q;  olast_d = olast_q;  okind_d = okind_q;  odata_d = odata_q;
    ram_we = 1'b0;  ram_waddr = '0;  ram_wdata = '0;
    div_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          now_d   = in_w.now_ms;
          seq_d   = in_w.seq;
          prior_d = in_w.prior_retries;
          ekind_d = KIND_STATUS;
          eseq_d  = '0;
          erc_d   = '0;
          elast_d = 1'b1;
          state_d = ST_EMIT;
          wcnt_d  = '0;
          match_d = 1'b0;
          free_d  = 1'b0;
          minf_d  = 1'b0;
          mask_d  = '0;
          mcnt_d  = '0;
          gcnt_d  = '0;
          case (in_w.action)
            ACT_RECV: begin
              lrx_d = in_w.now_ms;
              rcv_d = rcv_inc;
              if (in_w.seq > exp_q) begin
                lost_d = lost_q + (in_w.seq - exp_q);
                exp_d  = in_w.seq + 32'd1;
              end else if (in_w.seq == exp_q) begin
                exp_d = exp_q + 32'd1;
              end
              if (rcv_inc != '0) begin
                state_d = ST_DSTART;
              end
            end
            ACT_NEXT: begin
              ekind_d = KIND_OUTID;
              eseq_d  = nxt_q;
              nxt_d   = nxt_q + 32'd1;
            end
            ACT_ADD: begin
              wmode_d = W_ADD;
              state_d = ST_WALK;
            end
            ACT_ACK: begin
              wmode_d = W_ACK;
              state_d = ST_WALK;
            end
            ACT_SCAN: begin
              if (scen_q) begin
                wmode_d = W_SCAN;
                state_d = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          pct_d   = div_quot;
          state_d = ST_EMIT;
        end
      end
      ST_WALK: begin
        if (wcnt_q != '0) begin
          case (wmode_q)
            W_ADD: begin
              if (valid_q[pidx] && rd.seq == seq_q) begin
                match_d = 1'b1;
                midx_d  = pidx;
              end
              if (!valid_q[pidx] && !free_q) begin
                free_d = 1'b1;
                fidx_d = pidx;
              end
            end
            W_ACK: begin
              if (valid_q[pidx] && rd.seq == seq_q) begin
                match_d = 1'b1;
                midx_d  = pidx;
                mtime_d = rd.sent;
              end
              if (valid_q[pidx] && rd.seq != seq_q && (!minf_q || rd.seq < min_q)) begin
                minf_d = 1'b1;
                min_d  = rd.seq;
              end
            end
            W_SCAN: begin
              if (valid_q[pidx] && elapsed > rto_q) begin
                mask_d[pidx] = 1'b1;
                mcnt_d = mcnt_q + 1'b1;
                if (rinc >= maxr_q) begin
                  gcnt_d = gcnt_q + 1'b1;
                end
              end
            end
            default: begin
              if (mask_q[pidx] && (!self_q || rd.seq < sseq_q)) begin
                self_d = 1'b1;
                sidx_d = pidx;
                sseq_d = rd.seq;
                sret_d = rinc;
              end
            end
          endcase
        end
        wcnt_d = wcnt_q + 1'b1;
        if (wcnt_q == CNTW'(DEPTH)) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        state_d = ST_EMIT;
        case (wmode_q)
          W_ADD: begin
            if (match_q || free_q) begin
              ram_we    = 1'b1;
              ram_waddr = match_q ? midx_q : fidx_q;
              ram_wdata = '{retries: prior_q, sent: now_q, seq: seq_q};
              valid_d[ram_waddr] = 1'b1;
              cnt_d = newcnt;
              if (newcnt == CNTW'(1)) begin
                old_d = seq_q;
              end
            end else begin
              ekind_d = KIND_FULL;
              eseq_d  = seq_q;
            end
          end
          W_ACK: begin
            if (match_q) begin
              valid_d[midx_q] = 1'b0;
              cnt_d = cnt_q - 1'b1;
              rtt_d = now_q - mtime_q;
              if (cnt_q != CNTW'(1)) begin
                old_d = min_q;
              end
              state_d = ST_AVG1;
            end
          end
          W_SCAN: begin
            valid_d = valid_q & ~mask_q;
            cnt_d   = cnt_q - mcnt_q;
            lost_d  = lost_q + 32'(gcnt_q);
            if (now_q - lrx_q > ato_q) begin
              alive_d = 1'b0;
            end
            state_d = ST_SNEXT;
          end
          default: begin
            mask_d[sidx_q] = 1'b0;
            ekind_d = (sret_q >= maxr_q) ? KIND_GIVEUP : KIND_RETRY;
            eseq_d  = sseq_q;
            erc_d   = sret_q;
            elast_d = 1'b0;
          end
        endcase
      end
      ST_AVG1: begin
        if (avg_q == '0) begin
          avg_d   = pq;
          state_d = ST_EMIT;
        end else begin
          prod_d  = (avg_ext << 8) - (avg_ext << 3) - (avg_ext << 2) - avg_ext;
          state_d = ST_AVG2;
        end
      end
      ST_AVG2: begin
        avg_d   = sum_w[AVG_W+7:8];
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        ovalid_d = 1'b1;
        olast_d  = elast_q;
        okind_d  = ekind_q;
        odata_d  = '{oldest_unacked: old_q,
                     unacked_count:  6'(cnt_q),
                     ping_avg_q8:    avg_q,
                     ping_last_ms:   rtt_q,
                     loss_percent:   pct_q,
                     packets_lost:   lost_q,
                     packets_in:     rcv_q,
                     alive:          alive_q,
                     retry_count:    erc_q,
                     seq_out:        eseq_q};
        state_d  = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (m_axis_tready_i) begin
          ovalid_d = 1'b0;
          state_d  = elast_q ? ST_IDLE : ST_SNEXT;
        end
      end
      ST_SNEXT: begin
        if (mask_q == '0) begin
          ekind_d = KIND_STATUS;
          eseq_d  = '0;
          erc_d   = '0;
          elast_d = 1'b1;
          state_d = ST_EMIT;
        end else begin
          wmode_d = W_SEL;
          wcnt_d  = '0;
          self_d  = 1'b0;
          state_d = ST_WALK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rto_q    <= 32'd5000;
      ato_q    <= 32'd60000;
      maxr_q   <= 2'd3;
      scen_q   <= 1'b1;
      exp_q    <= '0;
      nxt_q    <= '0;
      rcv_q    <= '0;
      lost_q   <= '0;
      pct_q    <= '0;
      rtt_q    <= '0;
      old_q    <= '0;
      lrx_q    <= '0;
      avg_q    <= '0;
      alive_q  <= 1'b1;
      valid_q  <= '0;
      cnt_q    <= '0;
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RETRY_TO: rto_q  <= cfg_data_i;
          CFG_ALIVE_TO: ato_q  <= cfg_data_i;
          CFG_MAX_RETR: maxr_q <= cfg_data_i[1:0];
          CFG_SCAN_EN:  scen_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      exp_q    <= exp_d;
      nxt_q    <= nxt_d;
      rcv_q    <= rcv_d;
      lost_q   <= lost_d;
      pct_q    <= pct_d;
      rtt_q    <= rtt_d;
      old_q    <= old_d;
      lrx_q    <= lrx_d;
      avg_q    <= avg_d;
      alive_q  <= alive_d;
      valid_q  <= valid_d;
      cnt_q    <= cnt_d;
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wmode_q <= wmode_d;
    now_q   <= now_d;
    seq_q   <= seq_d;
    prior_q <= prior_d;
    wcnt_q  <= wcnt_d;
    match_q <= match_d;
    free_q  <= free_d;
    minf_q  <= minf_d;
    midx_q  <= midx_d;
    fidx_q  <= fidx_d;
    mtime_q <= mtime_d;
    min_q   <= min_d;
    mask_q  <= mask_d;
    mcnt_q  <= mcnt_d;
    gcnt_q  <= gcnt_d;
    self_q  <= self_d;
    sidx_q  <= sidx_d;
    sseq_q  <= sseq_d;
    sret_q  <= sret_d;
    prod_q  <= prod_d;
    ekind_q <= ekind_d;
    eseq_q  <= eseq_d;
    erc_q   <= erc_d;
    elast_q <= elast_d;
    olast_q <= olast_d;
    okind_q <= okind_d;
    odata_q <= odata_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tdata_o  = odata_q;

endmodule

[rtl/core/rlt_checker.sv]
// port-level checks of the link tracker, bound to the top level
// depends on rlt_pkg and reliable_link_tracker_unit_defines.svh
`include "reliable_link_tracker_unit_defines.svh"

module rlt_checker import rlt_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_tvalid_i,
  input logic         s_tready_i,
  input logic         m_tvalid_i,
  input logic         m_tready_i,
  input logic [215:0] m_tdata_i,
  input logic         m_tlast_i,
  input logic [2:0]   m_tuser_i
);

  `RLT_ASSERT_NEXT(a_out_hold, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i), "result word dropped or changed while stalled")

  `RLT_ASSERT_IMPL(a_one_side, s_tready_i, !m_tvalid_i, "input ready while a result word is pending")

  `RLT_ASSERT_NEXT(a_busy_after_take, s_tvalid_i && s_tready_i, !s_tready_i, "ready again right after taking a word")

  `RLT_ASSERT_IMPL(a_pct_range, m_tvalid_i, m_tdata_i[105:99] <= 7'd100, "loss percentage above 100")

  `RLT_ASSERT_IMPL(a_last_kind, m_tvalid_i && m_tlast_i, m_tuser_i != KIND_RETRY && m_tuser_i != KIND_GIVEUP, "retry or give-up marked as final word")

endmodule

bind reliable_link_tracker_unit rlt_checker u_rlt_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_tvalid_i(s_axis_tvalid_i),
  .s_tready_i(s_axis_tready_o),
  .m_tvalid_i(m_axis_tvalid_o),
  .m_tready_i(m_axis_tready_i),
  .m_tdata_i (m_axis_tdata_o),
  .m_tlast_i (m_axis_tlast_o),
  .m_tuser_i (m_axis_tuser_o)
);

[test/tb_reliable_link_tracker_unit.sv]
// self-checking testbench for reliable_link_tracker_unit: directed and random actions
// with a scoreboard class that predicts every result word; depends on rlt_pkg and the rtl
`timescale 1ns / 100ps

module tb_reliable_link_tracker_unit;
  import rlt_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic        last;
    out_data_t   data;
  } link_result_t;

  int unsigned fail_count = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    fail_count++;
  endtask

  class link_scoreboard;
    logic [31:0] retry_to, alive_to;
    logic [1:0]  max_retr;
    logic        scan_en;
    logic [31:0] exp_in, next_out, rx_cnt, lost_cnt, rtt_last, oldest, last_rx;
    logic [6:0]  pct;
    logic [39:0] rtt_avg;
    logic        alive;
    logic        ent_valid[DEPTH];
    logic [31:0] ent_seq[DEPTH];
    logic [31:0] ent_sent[DEPTH];
    logic [1:0]  ent_retr[DEPTH];
    link_result_t pending[$];

    function new();
      retry_to = 5000; alive_to = 60000; max_retr = 3; scan_en = 1;
      exp_in = 0; next_out = 0; rx_cnt = 0; lost_cnt = 0; rtt_last = 0;
      oldest = 0; last_rx = 0; pct = 0; rtt_avg = 0; alive = 1;
      foreach (ent_valid[i]) begin
        ent_valid[i] = 0; ent_seq[i] = 0; ent_sent[i] = 0; ent_retr[i] = 0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_RETRY_TO: retry_to = val;
        CFG_ALIVE_TO: alive_to = val;
        CFG_MAX_RETR: max_retr = val[1:0];
        default: scan_en = val[0];
      endcase
    endfunction

    function int held();
      int n = 0;
      foreach (ent_valid[i]) if (ent_valid[i]) n++;
      return n;
    endfunction

    function int find(logic [31:0] s);
      foreach (ent_valid[i]) if (ent_valid[i] && ent_seq[i] == s) return i;
      return -1;
    endfunction

    function void note_input(in_data_t w);
      link_result_t res[$];
      link_result_t r;
      int slot, m, t, j;
      int idx[$];
      logic [31:0] ping, mn;
      logic [39:0] pq;
      logic [63:0] num, den;
      logic [1:0]  rc;
      bit got;
      r.kind = KIND_STATUS; r.last = 0; r.data = '0;
      case (w.action)
        ACT_RECV: begin
          last_rx = w.now_ms;
          rx_cnt++;
          if (w.seq > exp_in) begin
            lost_cnt += w.seq - exp_in;
            exp_in = w.seq + 1;
          end else if (w.seq == exp_in) exp_in++;
          if (rx_cnt != 0) begin
            num = 64'(lost_cnt) * 100;
            den = 64'(rx_cnt) + 64'(lost_cnt);
            pct = 7'(num / den);
          end
          res.push_back(r);
        end
        ACT_NEXT: begin
          r.kind = KIND_OUTID; r.data.seq_out = next_out;
          next_out++;
          res.push_back(r);
        end
        ACT_ADD: begin
          slot = find(w.seq);
          if (slot < 0)
            foreach (ent_valid[i]) if (slot < 0 && !ent_valid[i]) slot = i;
          if (slot < 0) begin
            r.kind = KIND_FULL; r.data.seq_out = w.seq;
          end else begin
            ent_valid[slot] = 1; ent_seq[slot] = w.seq;
            ent_sent[slot] = w.now_ms; ent_retr[slot] = w.prior_retries;
            if (held() == 1) oldest = w.seq;
          end
          res.push_back(r);
        end
        ACT_ACK: begin
          slot = find(w.seq);
          if (slot >= 0) begin
            ping = w.now_ms - ent_sent[slot];
            pq = 40'(ping) << AVG_FRAC;
            if (rtt_avg == 0) rtt_avg = pq;
            else rtt_avg = 40'(((64'(rtt_avg) * 243) + (64'(pq) * 13)) >> 8);
            rtt_last = ping;
            ent_valid[slot] = 0;
            if (held() > 0) begin
              got = 0; mn = 0;
              foreach (ent_valid[i])
                if (ent_valid[i] && (!got || ent_seq[i] < mn)) begin
                  mn = ent_seq[i]; got = 1;
                end
              oldest = mn;
            end
          end
          res.push_back(r);
        end
        ACT_SCAN: begin
          if (scan_en) begin
            foreach (ent_valid[i])
              if (ent_valid[i] && (w.now_ms - ent_sent[i]) > retry_to) idx.push_back(i);
            m = idx.size();
            for (int i = 1; i < m; i++) begin
              t = idx[i]; j = i - 1;
              while (j >= 0 && ent_seq[idx[j]] > ent_seq[t]) begin
                idx[j + 1] = idx[j]; j--;
              end
              idx[j + 1] = t;
            end
            for (int i = 0; i < m; i++) begin
              rc = ent_retr[idx[i]];
              if (rc != 3) rc++;
              ent_retr[idx[i]] = rc;
              r.data.seq_out = ent_seq[idx[i]]; r.data.retry_count = rc;
              if (rc < max_retr) r.kind = KIND_RETRY;
              else begin
                r.kind = KIND_GIVEUP; lost_cnt++;
              end
              ent_valid[idx[i]] = 0;
              res.push_back(r);
            end
            if ((w.now_ms - last_rx) > alive_to) alive = 0;
          end
          r = '{KIND_STATUS, 0, '0};
          res.push_back(r);
        end
        default: res.push_back(r);
      endcase
      foreach (res[k]) begin
        res[k].last = (k == res.size() - 1);
        res[k].data.alive = alive;
        res[k].data.packets_in = rx_cnt;
        res[k].data.packets_lost = lost_cnt;
        res[k].data.loss_percent = pct;
        res[k].data.ping_last_ms = rtt_last;
        res[k].data.ping_avg_q8 = rtt_avg;
        res[k].data.unacked_count = 6'(held());
        res[k].data.oldest_unacked = oldest;
        pending.push_back(res[k]);
      end
    endfunction

    task check_result(logic [2:0] kind, logic last, out_data_t d);
      link_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word kind", kind, 0);
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind) report_mismatch("kind", kind, e.kind);
      if (last !== e.last) report_mismatch("last", last, e.last);
      if (d.seq_out !== e.data.seq_out) report_mismatch("seq_out", d.seq_out, e.data.seq_out);
      if (d.retry_count !== e.data.retry_count)
        report_mismatch("retry_count", d.retry_count, e.data.retry_count);
      if (d.alive !== e.data.alive) report_mismatch("alive", d.alive, e.data.alive);
      if (d.packets_in !== e.data.packets_in)
        report_mismatch("packets_in", d.packets_in, e.data.packets_in);
      if (d.packets_lost !== e.data.packets_lost)
        report_mismatch("packets_lost", d.packets_lost, e.data.packets_lost);
      if (d.loss_percent !== e.data.loss_percent)
        report_mismatch("loss_percent", d.loss_percent, e.data.loss_percent);
      if (d.ping_last_ms !== e.data.ping_last_ms)
        report_mismatch("ping_last_ms", d.ping_last_ms, e.data.ping_last_ms);
      if (d.ping_avg_q8 !== e.data.ping_avg_q8)
        report_mismatch("ping_avg_q8", d.ping_avg_q8, e.data.ping_avg_q8);
      if (d.unacked_count !== e.data.unacked_count)
        report_mismatch("unacked_count", d.unacked_count, e.data.unacked_count);
      if (d.oldest_unacked !== e.data.oldest_unacked)
        report_mismatch("oldest_unacked", d.oldest_unacked, e.data.oldest_unacked);
    endtask
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid_i = 0;
  logic         s_axis_tready_o;
  logic [71:0]  s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 0;
  logic [215:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;
  logic [2:0]   m_axis_tuser_o;
  logic         cfg_we_i = 0;
  logic [1:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;

  link_scoreboard sb = new();
  bit           sink_on = 0;
  logic [31:0]  clock_ms = 0;
  logic [31:0]  recent_seq[$];

  reliable_link_tracker_unit u_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tuser_o, m_axis_tlast_o, out_data_t'(m_axis_tdata_o));
  end

  initial begin : sink
    int unsigned g;
    forever begin
      @(posedge clk_i);
      g = gap_len();
      if (!sink_on || g == 0 || $urandom_range(0, 1)) m_axis_tready_i <= 1;
      else begin
        m_axis_tready_i <= 0;
        repeat (g) @(posedge clk_i);
        m_axis_tready_i <= 1;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic send_word(logic [2:0] act, logic [31:0] now, logic [31:0] s, logic [1:0] pr);
    in_data_t w;
    int unsigned g;
    w.action = act; w.now_ms = now; w.seq = s; w.prior_retries = pr;
    g = gap_len();
    repeat (g + 1) @(posedge clk_i);
    s_axis_tdata_i <= {3'd0, w};
    s_axis_tvalid_i <= 1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(w);
    s_axis_tvalid_i <= 0;
  endtask

  task automatic drain();
    int unsigned n = 0;
    while (sb.pending.size() != 0 && n < 200000) begin
      @(posedge clk_i); n++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_word();
    int unsigned p;
    logic [31:0] s;
    p = $urandom_range(0, 99);
    clock_ms += $urandom_range(0, 3000);
    s = (recent_seq.size() != 0 && $urandom_range(0, 2) != 0) ?
        recent_seq[$urandom_range(0, recent_seq.size() - 1)] : $urandom_range(0, 60);
    if ($urandom_range(0, 15) == 0) s = $urandom();
    if (p < 20) send_word(ACT_RECV, clock_ms, s, 0);
    else if (p < 30) send_word(ACT_NEXT, clock_ms, 0, 2'($urandom()));
    else if (p < 60) begin
      s = $urandom_range(0, 60);
      if ($urandom_range(0, 20) == 0) s = $urandom();
      recent_seq.push_back(s);
      if (recent_seq.size() > 40) void'(recent_seq.pop_front());
      send_word(ACT_ADD, clock_ms, s, 2'($urandom()));
    end
    else if (p < 80) send_word(ACT_ACK, clock_ms, s, 0);
    else if (p < 97) send_word(ACT_SCAN, clock_ms, s, 0);
    else send_word(3'($urandom_range(5, 7)), $urandom(), $urandom(), 2'($urandom()));
  endtask

  initial begin : stim
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    sink_on = 1;
    repeat (2) @(posedge clk_i);
    // directed: every action and the corner cases
    send_word(ACT_NEXT, 0, 0, 0);
    send_word(ACT_RECV, 10, 32'hffff_ffff, 0);
    send_word(ACT_RECV, 20, 0, 0);
    send_word(ACT_ADD, 100, 7, 3);
    send_word(ACT_ADD, 100, 3, 0);
    send_word(ACT_ADD, 150, 7, 1);
    send_word(ACT_ACK, 90, 3, 0);
    send_word(ACT_ACK, 200, 99, 0);
    send_word(ACT_ACK, 32'hffff_ffff, 7, 0);
    send_word(3'd5, 32'hffff_ffff, 32'hffff_ffff, 3);
    send_word(3'd7, 0, 0, 0);
    for (int i = 0; i < 33; i++) send_word(ACT_ADD, 1000, 32'(i + 100), 2'(i));
    send_word(ACT_SCAN, 9000, 0, 0);
    send_word(ACT_SCAN, 200000, 0, 0);
    drain();
    write_reg(CFG_RETRY_TO, 1);
    write_reg(CFG_ALIVE_TO, 32'hffff_ffff);
    write_reg(CFG_MAX_RETR, 1);
    write_reg(CFG_SCAN_EN, 0);
    clock_ms = 300000;
    for (int i = 0; i < 90; i++) random_word();
    drain();
    write_reg(CFG_SCAN_EN, 1);
    write_reg(CFG_MAX_RETR, 2);
    write_reg(CFG_RETRY_TO, 2000);
    for (int i = 0; i < 100; i++) random_word();
    drain();
    write_reg(CFG_RETRY_TO, 32'hffff_ffff);
    write_reg(CFG_MAX_RETR, 3);
    write_reg(CFG_ALIVE_TO, 1);
    for (int i = 0; i < 90; i++) random_word();
    drain();
    write_reg(CFG_RETRY_TO, $urandom_range(500, 8000));
    write_reg(CFG_ALIVE_TO, $urandom());
    for (int i = 0; i < 100; i++) random_word();
    drain();
    if (fail_count == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/rlt_pkg.sv
rtl/core/rlt_ram.sv
rtl/core/rlt_div.sv
rtl/core/reliable_link_tracker_unit.sv
rtl/core/rlt_checker.sv
test/tb_reliable_link_tracker_unit.sv
